// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
// No dependencies; simulation builds get the checks, synthesis gets empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
  `ASSERT_PROP(label, clk, rst_n, !(cond))

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== hw/rtl/xtea_pkg.sv =====
// Shared types, constants, microcode ROM and round function for the XTEA cipher.
// No dependencies.
package xtea_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned NUM_KEYS  = 4;
  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  localparam int unsigned STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT     = 3'd0;
  localparam step_t STEP_DISPATCH = 3'd1;
  localparam step_t STEP_ENC_A    = 3'd2;
  localparam step_t STEP_ENC_B    = 3'd3;
  localparam step_t STEP_ENC_EMIT = 3'd4;
  localparam step_t STEP_DEC_A    = 3'd5;
  localparam step_t STEP_DEC_B    = 3'd6;
  localparam step_t STEP_DEC_EMIT = 3'd7;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_NOP,
    OP_ENC_A,
    OP_ENC_B,
    OP_DEC_A,
    OP_DEC_B,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NOT_START,
    COND_DECRYPT,
    COND_NOT_LAST
  } cond_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_A = 2'd0,
    REG_KEY_B = 2'd1,
    REG_KEY_C = 2'd2,
    REG_KEY_D = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic start;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic decrypt;
    logic emit_ok;
  } dp_stat_t;

  typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_t;

  function automatic uword_t ucode(step_t s);
    uword_t w;
    unique case (s)
      STEP_WAIT:     w = '{op: OP_LOAD,  cond: COND_NOT_START, target: STEP_WAIT};
      STEP_DISPATCH: w = '{op: OP_NOP,   cond: COND_DECRYPT,   target: STEP_DEC_A};
      STEP_ENC_A:    w = '{op: OP_ENC_A, cond: COND_NEXT,      target: STEP_WAIT};
      STEP_ENC_B:    w = '{op: OP_ENC_B, cond: COND_NOT_LAST,  target: STEP_ENC_A};
      STEP_ENC_EMIT: w = '{op: OP_EMIT,  cond: COND_ALWAYS,    target: STEP_WAIT};
      STEP_DEC_A:    w = '{op: OP_DEC_A, cond: COND_NEXT,      target: STEP_WAIT};
      STEP_DEC_B:    w = '{op: OP_DEC_B, cond: COND_NOT_LAST,  target: STEP_DEC_A};
      STEP_DEC_EMIT: w = '{op: OP_EMIT,  cond: COND_ALWAYS,    target: STEP_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] mix(logic [WORD_W-1:0] v,
                                            logic [WORD_W-1:0] s,
                                            logic [WORD_W-1:0] kw);
    return (((v << 4) ^ (v >> 5)) + v) ^ (s + kw);
  endfunction

endpackage

// ===== hw/rtl/xtea_seq.sv =====
// Microcode sequencer: step counter, ROM lookup, jump logic and round counter.
// Depends on xtea_pkg.
module xtea_seq #(
  parameter int unsigned NUM_CYCLES = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  xtea_pkg::dp_stat_t stat_i,
  output xtea_pkg::ctrl_t    ctrl_o,
  output logic               in_stall_o
);

  localparam int unsigned CNT_W = (NUM_CYCLES > 1) ? $clog2(NUM_CYCLES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_CYCLES - 1);

  xtea_pkg::step_t  step_q, step_d, step_inc;
  xtea_pkg::uword_t uw;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             last;

  always_comb begin
    uw           = xtea_pkg::ucode(step_q);
    last         = (cnt_q == CNT_LAST);
    step_inc     = step_q + xtea_pkg::step_t'(1);
    ctrl_o.op    = uw.op;
    ctrl_o.start = (uw.op == xtea_pkg::OP_LOAD) && in_valid_i;
    ctrl_o.emit  = (uw.op == xtea_pkg::OP_EMIT) && stat_i.emit_ok;
    in_stall_o   = (uw.op != xtea_pkg::OP_LOAD);
  end

  always_comb begin
    unique case (uw.cond)
      xtea_pkg::COND_NEXT:      step_d = step_inc;
      xtea_pkg::COND_ALWAYS:    step_d = uw.target;
      xtea_pkg::COND_NOT_START: step_d = ctrl_o.start ? step_inc : uw.target;
      xtea_pkg::COND_DECRYPT:   step_d = stat_i.decrypt ? uw.target : step_inc;
      xtea_pkg::COND_NOT_LAST:  step_d = last ? step_inc : uw.target;
      default:                  step_d = xtea_pkg::STEP_WAIT;
    endcase
    if ((uw.op == xtea_pkg::OP_EMIT) && !stat_i.emit_ok) begin
      step_d = step_q;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_o.start) begin
      cnt_d = '0;
    end else if ((uw.op == xtea_pkg::OP_ENC_B) || (uw.op == xtea_pkg::OP_DEC_B)) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= xtea_pkg::STEP_WAIT;
      cnt_q  <= '0;
    end else begin
      step_q <= step_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/xtea_dp.sv =====
// Datapath: block halves, running sum, shared half-round unit, result register.
// Depends on xtea_pkg; driven by xtea_seq.
module xtea_dp #(
  parameter int unsigned NUM_CYCLES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  xtea_pkg::ctrl_t               ctrl_i,
  input  xtea_pkg::key_t                keys_i,
  input  logic [xtea_pkg::WORD_W-1:0]   block_left_i,
  input  logic [xtea_pkg::WORD_W-1:0]   block_right_i,
  input  logic                          func_i,
  input  logic                          out_stall_i,
  output xtea_pkg::dp_stat_t            stat_o,
  output logic                          out_valid_o,
  output logic [xtea_pkg::WORD_W-1:0]   result_left_o,
  output logic [xtea_pkg::WORD_W-1:0]   result_right_o
);

  localparam logic [63:0] SUM_DEC_FULL = 64'(xtea_pkg::DELTA) * 64'(NUM_CYCLES);
  localparam logic [xtea_pkg::WORD_W-1:0] SUM_DEC = SUM_DEC_FULL[xtea_pkg::WORD_W-1:0];

  logic [xtea_pkg::WORD_W-1:0] left_q, left_d, right_q, right_d, sum_q, sum_d;
  logic [xtea_pkg::WORD_W-1:0] res_l_q, res_r_q, mix_v, mix_r;
  logic [1:0]                  kidx;
  logic                        dec_q, dec_d, out_valid_q, out_valid_d;

  always_comb begin
    kidx  = ((ctrl_i.op == xtea_pkg::OP_ENC_B) || (ctrl_i.op == xtea_pkg::OP_DEC_A))
          ? sum_q[12:11] : sum_q[1:0];
    mix_v = ((ctrl_i.op == xtea_pkg::OP_ENC_A) || (ctrl_i.op == xtea_pkg::OP_DEC_B))
          ? right_q : left_q;
    mix_r = xtea_pkg::mix(mix_v, sum_q, keys_i[kidx]);
  end

  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    sum_d   = sum_q;
    dec_d   = dec_q;
    unique case (ctrl_i.op)
      xtea_pkg::OP_LOAD: begin
        if (ctrl_i.start) begin
          left_d  = block_left_i;
          right_d = block_right_i;
          dec_d   = func_i;
          sum_d   = func_i ? SUM_DEC : '0;
        end
      end
      xtea_pkg::OP_ENC_A: begin
        left_d = left_q + mix_r;
        sum_d  = sum_q + xtea_pkg::DELTA;
      end
      xtea_pkg::OP_ENC_B: right_d = right_q + mix_r;
      xtea_pkg::OP_DEC_A: begin
        right_d = right_q - mix_r;
        sum_d   = sum_q - xtea_pkg::DELTA;
      end
      xtea_pkg::OP_DEC_B: left_d = left_q - mix_r;
      default: ;
    endcase
  end

  always_comb begin
    stat_o.decrypt = dec_q;
    stat_o.emit_ok = !out_valid_q || !out_stall_i;
    out_valid_d    = out_valid_q;
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    left_q  <= left_d;
    right_q <= right_d;
    sum_q   <= sum_d;
    dec_q   <= dec_d;
    if (ctrl_i.emit) begin
      res_l_q <= left_q;
      res_r_q <= right_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_left_o  = res_l_q;
  assign result_right_o = res_r_q;

endmodule

// ===== hw/rtl/xtea_block_cipher.sv =====
// XTEA cipher top level: key registers, sequencer and datapath.
// Depends on xtea_pkg, xtea_seq, xtea_dp and assert_macros.svh.
//
//   channel  handshake               payload
//   cfg      cfg_we_i                cfg_idx_i, cfg_data_i
//   in       in_valid_i/in_stall_o   block_left_i, block_right_i, func_i
//   out      out_valid_o/out_stall_i result_left_o, result_right_o
//
// A word runs one half-round per clock through the shared round unit, plus
// load, dispatch and emit steps.
// The result register lets the next word load while a result waits; the emit
// step holds while that register is still full and stalled.
// Reset clears the key words, the step and round counters and the output valid.
`include "assert_macros.svh"

module xtea_block_cipher #(
  parameter int unsigned NUM_CYCLES = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [xtea_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [xtea_pkg::WORD_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [xtea_pkg::WORD_W-1:0]      block_left_i,
  input  logic [xtea_pkg::WORD_W-1:0]      block_right_i,
  input  logic                             func_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [xtea_pkg::WORD_W-1:0]      result_left_o,
  output logic [xtea_pkg::WORD_W-1:0]      result_right_o
);

  xtea_pkg::key_t     key_q, key_d;
  xtea_pkg::ctrl_t    ctrl;
  xtea_pkg::dp_stat_t stat;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      unique case (xtea_pkg::cfg_reg_e'(cfg_idx_i))
        xtea_pkg::REG_KEY_A: key_d[0] = cfg_data_i;
        xtea_pkg::REG_KEY_B: key_d[1] = cfg_data_i;
        xtea_pkg::REG_KEY_C: key_d[2] = cfg_data_i;
        xtea_pkg::REG_KEY_D: key_d[3] = cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  xtea_seq #(
    .NUM_CYCLES (NUM_CYCLES)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .in_stall_o (in_stall_o)
  );

  xtea_dp #(
    .NUM_CYCLES (NUM_CYCLES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .keys_i         (key_q),
    .block_left_i   (block_left_i),
    .block_right_i  (block_right_i),
    .func_i         (func_i),
    .out_stall_i    (out_stall_i),
    .stat_o         (stat),
    .out_valid_o    (out_valid_o),
    .result_left_o  (result_left_o),
    .result_right_o (result_right_o)
  );

  `ASSERT_PROP(a_busy_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `ASSERT_PROP(a_valid_from_emit, clk_i, rst_ni, $rose(out_valid_o) |-> $past(ctrl.emit))
  `ASSERT_PROP(a_idle_after_emit, clk_i, rst_ni, $fell(in_stall_o) |-> $past(ctrl.emit))

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for xtea_block_cipher: programs the key, streams blocks both ways
// and checks every result against an XTEA model computed here.
// Depends on xtea_pkg and the xtea_block_cipher RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROUNDS     = 32;
  localparam int unsigned IDLE_PCT   = 28;
  localparam int unsigned QUIET_MAX  = 3000;
  localparam int unsigned PHASES     = 10;
  localparam int unsigned PHASE_LEN  = 185;
  localparam int unsigned TAIL_WAIT  = 80;

  typedef struct packed {
    logic [xtea_pkg::WORD_W-1:0] left;
    logic [xtea_pkg::WORD_W-1:0] right;
    logic                        decrypt;
  } cipher_job_t;

  typedef struct packed {
    logic [xtea_pkg::WORD_W-1:0] left;
    logic [xtea_pkg::WORD_W-1:0] right;
  } block_pair_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [xtea_pkg::CFG_IDX_W-1:0] cfg_idx_i = xtea_pkg::REG_KEY_A;
  logic [xtea_pkg::WORD_W-1:0]    cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [xtea_pkg::WORD_W-1:0]    block_left_i = '0;
  logic [xtea_pkg::WORD_W-1:0]    block_right_i = '0;
  logic                           func_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [xtea_pkg::WORD_W-1:0]    result_left_o;
  logic [xtea_pkg::WORD_W-1:0]    result_right_o;

  cipher_job_t    job_q[$];
  block_pair_t    cipher_expect_q[$];
  xtea_pkg::key_t key_now = '0;
  logic           steady = 1'b0;
  int unsigned    mismatches = 0;
  int unsigned    quiet = 0;

  xtea_block_cipher #(.NUM_CYCLES(ROUNDS)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .block_left_i, .block_right_i, .func_i,
    .out_valid_o, .out_stall_i, .result_left_o, .result_right_o
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [xtea_pkg::WORD_W-1:0] feistel(
      logic [xtea_pkg::WORD_W-1:0] v, logic [xtea_pkg::WORD_W-1:0] s,
      logic [xtea_pkg::WORD_W-1:0] kw);
    return (((v << 4) ^ (v >> 5)) + v) ^ (s + kw);
  endfunction

  function automatic block_pair_t xtea_crypt(logic [xtea_pkg::WORD_W-1:0] l,
                                             logic [xtea_pkg::WORD_W-1:0] r,
                                             logic dec, xtea_pkg::key_t k);
    logic [xtea_pkg::WORD_W-1:0] v0;
    logic [xtea_pkg::WORD_W-1:0] v1;
    logic [xtea_pkg::WORD_W-1:0] s;
    block_pair_t res;
    v0 = l;
    v1 = r;
    if (!dec) begin
      s = '0;
      for (int n = 0; n < ROUNDS; n++) begin
        v0 = v0 + feistel(v1, s, k[s[1:0]]);
        s = s + xtea_pkg::DELTA;
        v1 = v1 + feistel(v0, s, k[s[12:11]]);
      end
    end else begin
      s = xtea_pkg::DELTA * 32'(ROUNDS);
      for (int n = 0; n < ROUNDS; n++) begin
        v1 = v1 - feistel(v0, s, k[s[12:11]]);
        s = s - xtea_pkg::DELTA;
        v0 = v0 - feistel(v1, s, k[s[1:0]]);
      end
    end
    res.left = v0;
    res.right = v1;
    return res;
  endfunction

  function automatic logic [xtea_pkg::WORD_W-1:0] rand_word();
    logic [xtea_pkg::WORD_W-1:0] w;
    case ($urandom_range(7))
      0: w = '0;
      1: w = '1;
      2: w = 32'd1 << $urandom_range(31);
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic xtea_pkg::key_t rand_key();
    xtea_pkg::key_t k;
    for (int i = 0; i < xtea_pkg::NUM_KEYS; i++) begin
      case ($urandom_range(5))
        0: k[i] = '0;
        1: k[i] = '1;
        default: k[i] = $urandom;
      endcase
    end
    return k;
  endfunction

  task automatic write_reg(xtea_pkg::cfg_reg_e idx, logic [xtea_pkg::WORD_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
  endtask

  // only called with the block idle
  task automatic program_key(xtea_pkg::key_t k);
    write_reg(xtea_pkg::REG_KEY_A, k[0]);
    write_reg(xtea_pkg::REG_KEY_B, k[1]);
    write_reg(xtea_pkg::REG_KEY_C, k[2]);
    write_reg(xtea_pkg::REG_KEY_D, k[3]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    key_now = k;
  endtask

  task automatic queue_block(logic [xtea_pkg::WORD_W-1:0] l, logic [xtea_pkg::WORD_W-1:0] r,
                             logic dec);
    cipher_job_t j;
    j.left = l;
    j.right = r;
    j.decrypt = dec;
    job_q.push_back(j);
  endtask

  // sampled at the falling edge, after the driver and monitor have settled
  task automatic drain();
    do @(negedge clk_i);
    while (job_q.size() != 0 || in_valid_i || cipher_expect_q.size() != 0);
  endtask

  task automatic note_mismatch(string what, logic [xtea_pkg::WORD_W-1:0] want,
                               logic [xtea_pkg::WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  // input driver
  always @(posedge clk_i) begin : feed
    cipher_job_t j;
    logic present;
    present = in_valid_i;
    if (in_valid_i && !in_stall_o) begin
      cipher_expect_q.push_back(xtea_crypt(block_left_i, block_right_i, func_i, key_now));
      present = 1'b0;
    end
    if (!present && job_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
      j = job_q.pop_front();
      block_left_i <= j.left;
      block_right_i <= j.right;
      func_i <= j.decrypt;
      present = 1'b1;
    end
    in_valid_i <= present;
  end

  // result monitor
  always @(posedge clk_i) begin : sink
    block_pair_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cipher_expect_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word %h_%h", result_left_o, result_right_o);
      end else begin
        want = cipher_expect_q.pop_front();
        if (result_left_o !== want.left) note_mismatch("result_left", want.left, result_left_o);
        if (result_right_o !== want.right)
          note_mismatch("result_right", want.right, result_right_o);
      end
    end
    out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet <= 0;
      else
        quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("watchdog: no handshake for %0d cycles", quiet);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin : stimulus
    xtea_pkg::key_t k;
    block_pair_t ct;
    logic [xtea_pkg::WORD_W-1:0] l;
    logic [xtea_pkg::WORD_W-1:0] r;
    int unsigned cnt;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset key, then written as zero explicitly
    queue_block('0, '0, 1'b0);
    queue_block('1, '1, 1'b1);
    drain();
    program_key('0);
    queue_block('0, '0, 1'b1);
    queue_block('1, '1, 1'b0);
    queue_block('0, '1, 1'b0);
    queue_block('1, '0, 1'b1);
    queue_block(32'h8000_0000, 32'h0000_0001, 1'b0);
    queue_block(32'h0000_0001, 32'h8000_0000, 1'b1);
    drain();

    program_key('1);
    queue_block('0, '0, 1'b0);
    queue_block('1, '1, 1'b0);
    queue_block('0, '0, 1'b1);
    queue_block('1, '1, 1'b1);
    queue_block(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    queue_block(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    drain();

    k[0] = 32'h0001_0203;
    k[1] = 32'h0405_0607;
    k[2] = 32'h0809_0A0B;
    k[3] = 32'h0C0D_0E0F;
    program_key(k);
    queue_block(32'h4142_4344, 32'h4546_4748, 1'b0);
    queue_block(32'h497D_F3D0, 32'h7261_2CB5, 1'b1);
    ct = xtea_crypt(32'h0123_4567, 32'h89AB_CDEF, 1'b0, k);
    queue_block(32'h0123_4567, 32'h89AB_CDEF, 1'b0);
    queue_block(ct.left, ct.right, 1'b1);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      k = rand_key();
      program_key(k);
      steady = (p == 4);
      cnt = 0;
      while (cnt < PHASE_LEN) begin
        l = rand_word();
        r = rand_word();
        if ($urandom_range(9) < 4) begin
          // round trip: the decrypt must give the plaintext back
          ct = xtea_crypt(l, r, 1'b0, k);
          queue_block(l, r, 1'b0);
          queue_block(ct.left, ct.right, 1'b1);
          cnt += 2;
        end else begin
          queue_block(l, r, 1'($urandom_range(1)));
          cnt++;
        end
      end
      drain();
      steady = 1'b0;
    end

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatches == 0 && cipher_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
